>>> design/sine_tone_generator_core_defines.svh
// Assertion macros for the sine tone generator core.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef SINE_TONE_GENERATOR_CORE_DEFINES_SVH
`define SINE_TONE_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define STG_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sine tone generator assertion failed");
// Next-cycle implication, checked outside reset.
`define STG_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sine tone generator assertion failed");
`else
`define STG_ASSERT_IMP(name, ante, cons)
`define STG_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> design/stg_pkg.sv
// Shared constants, types and the arctangent table of the sine tone generator.
// No dependencies; every other file of the block but stg_tick_if and the defines header uses it.
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

    // Phase accumulator and sine iteration setup.
    localparam int PHASE_BITS   = 32;
    localparam int SINE_STEPS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STEPS = (SINE_STEPS < ATAN_ENTRIES) ? SINE_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

    // Fixed-point formats.
    localparam int FRAC_W     = 30;   // angle within a quadrant, fraction of a quarter turn
    localparam int ANGLE_W    = 31;   // radians with 30 fractional bits, below pi/2
    localparam int Z_W        = 33;   // residual angle, signed
    localparam int XY_W       = 34;   // vector components, signed, 16 fractional bits
    localparam int OUT_FRAC   = 16;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = XY_W - OUT_FRAC;

    localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [XY_W-1:0]    START_X     = 34'd1301359557;
    localparam logic [MAG_W-1:0]   AMPLITUDE   = 18'd32700;

    // Configuration registers.
    localparam int PHASE_STEP_W = 32;
    localparam int INDEX_W      = 24;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 1;
    localparam logic [INDEX_W-1:0]   TONE_LENGTH_RESET = 24'd44100;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH   = 1'd1;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  last;
    } phase_info_t;

    typedef struct packed {
        logic           start;
        logic [Z_W-1:0] z_init;
    } cordic_cmd_t;

    typedef struct packed {
        logic            done;
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
    } cordic_stat_t;

    // atan(2^-i) in radians with 30 fractional bits.
    function automatic logic [ANGLE_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 31'd843314857;
            5'd1:    val = 31'd497837829;
            5'd2:    val = 31'd263043837;
            5'd3:    val = 31'd133525159;
            5'd4:    val = 31'd67021687;
            5'd5:    val = 31'd33543516;
            5'd6:    val = 31'd16775851;
            5'd7:    val = 31'd8388437;
            5'd8:    val = 31'd4194283;
            5'd9:    val = 31'd2097149;
            5'd10:   val = 31'd1048576;
            5'd11:   val = 31'd524288;
            5'd12:   val = 31'd262144;
            5'd13:   val = 31'd131072;
            5'd14:   val = 31'd65536;
            5'd15:   val = 31'd32768;
            5'd16:   val = 31'd16384;
            5'd17:   val = 31'd8192;
            5'd18:   val = 31'd4096;
            5'd19:   val = 31'd2048;
            5'd20:   val = 31'd1024;
            5'd21:   val = 31'd512;
            5'd22:   val = 31'd256;
            5'd23:   val = 31'd128;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> design/stg_tick_if.sv
// Input channel of the sine tone generator: one request per sample.
// Depends on nothing but the handshake convention of the block.
`timescale 1ns / 1ps
`default_nettype none

interface stg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> design/stg_sample_if.sv
// Output channel of the sine tone generator: one PCM sample per request.
// Depends on stg_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface stg_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [stg_pkg::SAMPLE_W-1:0] sample;
    logic                                is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink   (input valid, input sample, input is_last, output ready);
endinterface

`default_nettype wire

>>> design/sine_tone_generator_core.sv
// Top level of the sine tone generator: sequencer, angle scaling and output register.
// Depends on stg_pkg, stg_tick_if, stg_sample_if, stg_phase, stg_cordic and the defines header.
//
//   channel   dir   payload                 notes
//   tick      in    restart                 one request per sample
//   samples   out   sample, is_last         registered, held until taken
//   cfg_*     in    phase_step, tone_length write only
//
// Once accepted, a request passes the angle multiply, 16 iterations of the shared
// CORDIC unit, and the hand-off and output formatting before the next request can be taken.
// The finished sample waits in the output register; the sequencer stalls in its last
// state only if the previous sample has not been taken yet.
// Reset clears the sequencer, phase, sample index and phase step; tone length resets to 44100.
`timescale 1ns / 1ps
`default_nettype none

`include "sine_tone_generator_core_defines.svh"

module sine_tone_generator_core (
    input  wire                               clk,
    input  wire                               rst_n,
    stg_tick_if.sink                          tick,
    stg_sample_if.source                      samples,
    input  wire                               cfg_we,
    input  wire [stg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [stg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PB = stg_pkg::PHASE_BITS;
    localparam int FW = stg_pkg::FRAC_W;
    localparam int AW = stg_pkg::ANGLE_W;
    localparam int XW = stg_pkg::XY_W;
    localparam int PAD_W = PB - 2 + FW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL    = 2'd1;
    localparam logic [1:0] ST_ITER   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic [FW-1:0]                       frac_reg, frac_next;
    logic [1:0]                          quad_reg, quad_next;
    logic                                last_reg, last_next;
    logic [stg_pkg::SAMPLE_W-1:0]        sample_reg, sample_next;
    logic                                is_last_reg, is_last_next;

    stg_pkg::cfg_write_t   cfg;
    stg_pkg::phase_info_t  pinfo;
    stg_pkg::cordic_cmd_t  ccmd;
    stg_pkg::cordic_stat_t cstat;

    logic                 in_fire;
    logic                 out_free;
    logic                 out_in_range;
    logic [PAD_W-1:0]     frac_pad;
    logic [FW+AW-1:0]     product;
    logic signed [XW-1:0] v_sel;
    logic signed [XW-1:0] v_signed;
    logic [XW-1:0]        v_mag;
    logic [stg_pkg::MAG_W-1:0] t_mag;
    logic [stg_pkg::MAG_W-1:0] t_clamped;
    logic [stg_pkg::SAMPLE_W-1:0] t_final;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign tick.ready = (state_reg == ST_IDLE);
    assign in_fire    = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || samples.ready;

    stg_phase u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (tick.restart),
        .advance (in_fire),
        .info    (pinfo)
    );

    // The angle within the quadrant, aligned to 30 bits, scaled to radians.
    assign frac_pad = {pinfo.phase[PB-3:0], FW'(0)};
    assign product  = frac_reg * stg_pkg::HALF_PI_Q30;

    assign ccmd.start  = (state_reg == ST_MUL);
    assign ccmd.z_init = stg_pkg::Z_W'(product[FW+AW-1:FW]);

    stg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ccmd),
        .stat  (cstat)
    );

    // Quadrant fold, then truncation toward zero and clamping to the amplitude.
    always_comb
    begin
        v_sel     = quad_reg[0] ? signed'(cstat.x) : signed'(cstat.y);
        v_signed  = quad_reg[1] ? -v_sel : v_sel;
        v_mag     = v_signed[XW-1] ? XW'(-v_signed) : XW'(v_signed);
        t_mag     = v_mag[XW-1:stg_pkg::OUT_FRAC];
        t_clamped = (t_mag > stg_pkg::AMPLITUDE) ? stg_pkg::AMPLITUDE : t_mag;
        t_final   = v_signed[XW-1] ? stg_pkg::SAMPLE_W'(-t_clamped)
                                   : stg_pkg::SAMPLE_W'(t_clamped);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        frac_next      = frac_reg;
        quad_next      = quad_reg;
        last_next      = last_reg;
        sample_next    = sample_reg;
        is_last_next   = is_last_reg;

        if (out_valid_reg && samples.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    frac_next  = frac_pad[PAD_W-1 -: FW];
                    quad_next  = pinfo.phase[PB-1:PB-2];
                    last_next  = pinfo.last;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                if (cstat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    sample_next    = t_final;
                    is_last_next   = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg    <= frac_next;
        quad_reg    <= quad_next;
        last_reg    <= last_next;
        sample_reg  <= sample_next;
        is_last_reg <= is_last_next;
    end

    assign samples.valid   = out_valid_reg;
    assign samples.sample  = signed'(sample_reg);
    assign samples.is_last = is_last_reg;

    assign out_in_range = (samples.sample <= 16'sd32700) && (samples.sample >= -16'sd32700);

    `STG_ASSERT_NEXT(a_busy_after_accept, in_fire, !tick.ready)
    `STG_ASSERT_IMP(a_done_only_iterating, cstat.done, state_reg == ST_ITER)
    `STG_ASSERT_IMP(a_sample_in_range, samples.valid, out_in_range)
    `STG_ASSERT_NEXT(a_finish_loads_output, (state_reg == ST_FINISH) && out_free, samples.valid && (state_reg == ST_IDLE))

endmodule

`default_nettype wire

>>> design/stg_phase.sv
// Configuration registers, phase accumulator and sample counter.
// Depends on stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_phase (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire stg_pkg::cfg_write_t cfg,
    input  wire                  restart,
    input  wire                  advance,
    output stg_pkg::phase_info_t info
);

    localparam int PB = stg_pkg::PHASE_BITS;
    localparam int IW = stg_pkg::INDEX_W;

    logic [stg_pkg::PHASE_STEP_W-1:0] phase_step_reg, phase_step_next;
    logic [IW-1:0]                    tone_length_reg, tone_length_next;
    logic [PB-1:0]                    phase_acc_reg, phase_acc_next;
    logic [IW-1:0]                    sample_index_reg, sample_index_next;

    logic [PB-1:0] phase_cur;
    logic [IW-1:0] index_cur;
    logic          last_cur;

    // A restart request sees phase and index at zero before its own sample.
    always_comb
    begin
        phase_cur = restart ? '0 : phase_acc_reg;
        index_cur = restart ? '0 : sample_index_reg;
        last_cur  = (index_cur == IW'(tone_length_reg - 1'b1));
    end

    assign info.phase = phase_cur;
    assign info.last  = last_cur;

    always_comb
    begin
        phase_step_next   = phase_step_reg;
        tone_length_next  = tone_length_reg;
        phase_acc_next    = phase_acc_reg;
        sample_index_next = sample_index_reg;

        if (cfg.we)
        begin
            unique case (cfg.index)
                stg_pkg::REG_PHASE_STEP:  phase_step_next  = cfg.data[stg_pkg::PHASE_STEP_W-1:0];
                stg_pkg::REG_TONE_LENGTH: tone_length_next = cfg.data[IW-1:0];
                default: ;
            endcase
        end

        if (advance)
        begin
            if (last_cur)
            begin
                phase_acc_next    = '0;
                sample_index_next = '0;
            end
            else
            begin
                phase_acc_next    = phase_cur + PB'(phase_step_reg);
                sample_index_next = index_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            tone_length_reg  <= stg_pkg::TONE_LENGTH_RESET;
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
        end
        else
        begin
            phase_step_reg   <= phase_step_next;
            tone_length_reg  <= tone_length_next;
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
        end
    end

endmodule

`default_nettype wire

>>> design/stg_cordic.sv
// Rotation-mode CORDIC: one shift-add-subtract unit stepped once per cycle.
// Depends on stg_pkg for formats and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module stg_cordic (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire stg_pkg::cordic_cmd_t cmd,
    output stg_pkg::cordic_stat_t stat
);

    localparam int XW = stg_pkg::XY_W;
    localparam int ZW = stg_pkg::Z_W;
    localparam int SW = stg_pkg::STEP_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(stg_pkg::CORDIC_STEPS - 1);

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SW-1:0]        step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] angle;

    always_comb
    begin
        // Arithmetic shifts round toward minus infinity.
        dx    = y_reg >>> step_reg;
        dy    = x_reg >>> step_reg;
        angle = signed'(ZW'(stg_pkg::atan_q30(stg_pkg::ATAN_IDX_W'(step_reg))));

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            x_next    = signed'(stg_pkg::START_X);
            y_next    = '0;
            z_next    = signed'(cmd.z_init);
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ZW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - angle;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + angle;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign stat.done = done_reg;
    assign stat.x    = x_reg;
    assign stat.y    = y_reg;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for sine_tone_generator_core: a directed table, then random phases.
// A CORDIC predictor checks every sample. Needs stg_pkg, stg_tick_if, stg_sample_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import stg_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_last;
    } tone_sample_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          data;
        logic                 restart;
        logic                 exp_last;
    } dir_row_t;

    localparam longint TONE_HALF_PI = 64'd1686629713;
    localparam longint CORDIC_X0    = 64'd1301359557;
    localparam longint PEAK         = 64'd32700;
    localparam longint ATAN_TBL [0:15] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768};
    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_ITEMS  = 1080;
    localparam int QUIET_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int DIRECTED_ROWS = 36;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stg_tick_if   tick_ch ();
    stg_sample_if sample_ch ();

    sine_tone_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .samples   (sample_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and register copies.
    logic [31:0]      step_reg;
    logic [INDEX_W-1:0] length_reg;
    logic [31:0]      tone_phase;
    logic [INDEX_W-1:0] tone_index;

    tone_sample_t expected_samples[$];

    int  mismatch_count;
    int  samples_checked;
    int  last_marks;
    int  requests_sent;
    int  writes_done;
    bit  sender_gaps;
    bit  sink_stalls;
    bit  hold_req;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b1, 1'b0},
        '{ROW_WRITE, REG_TONE_LENGTH, 32'h1,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b1, 1'b1},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b1},
        '{ROW_WRITE, REG_PHASE_STEP,  32'h40000000, 1'b0, 1'b0},
        '{ROW_WRITE, REG_TONE_LENGTH, 32'h4,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b1, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b1},
        '{ROW_WRITE, REG_PHASE_STEP,  32'hFFFFFFFF, 1'b0, 1'b0},
        '{ROW_WRITE, REG_TONE_LENGTH, 32'hFFFFFFFF, 1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_WRITE, REG_PHASE_STEP,  32'h20000000, 1'b0, 1'b0},
        '{ROW_WRITE, REG_TONE_LENGTH, 32'h3,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b1, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b1, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b1},
        // A zero length puts the end mark at the top of the index range.
        '{ROW_WRITE, REG_TONE_LENGTH, 32'hFF000000, 1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_WRITE, REG_PHASE_STEP,  32'h01234567, 1'b0, 1'b0},
        '{ROW_WRITE, REG_TONE_LENGTH, 32'h5A000008, 1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b1, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        // Shrinking the length below the running index: no mark until a restart.
        '{ROW_WRITE, REG_TONE_LENGTH, 32'h2,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b1, 1'b0},
        '{ROW_TICK,  REG_PHASE_STEP,  32'h0,        1'b0, 1'b1}
    };

    // Rotation-mode CORDIC on one quadrant, then quadrant mapping, truncation and clamping.
    function automatic logic signed [SAMPLE_W-1:0] cordic_sine(input logic [31:0] phase);
        logic [63:0] angle_prod;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint v;
        longint t;
        angle_prod = 64'(phase[29:0]) * 64'(TONE_HALF_PI);
        z = longint'(angle_prod >> 30);
        x = CORDIC_X0;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TBL[i];
            end
            else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TBL[i];
            end
        end
        v = phase[30] ? x : y;
        if (phase[31])
            v = -v;
        t = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
        if (t > PEAK)
            t = PEAK;
        if (t < -PEAK)
            t = -PEAK;
        return t[SAMPLE_W-1:0];
    endfunction

    function automatic tone_sample_t next_tone_sample(input logic restart);
        tone_sample_t res;
        if (restart) begin
            tone_phase = '0;
            tone_index = '0;
        end
        res.sample  = cordic_sine(tone_phase);
        res.is_last = (tone_index == length_reg - 1'b1);
        if (res.is_last) begin
            tone_phase = '0;
            tone_index = '0;
        end
        else begin
            tone_phase = tone_phase + step_reg;
            tone_index = tone_index + 1'b1;
        end
        return res;
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d samples still outstanding.", expected_samples.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sample sink: checks every accepted sample and drives ready with stalls and long holds.
    initial begin : sample_sink
        int stall_left;
        int hold_left;
        tone_sample_t exp_s;
        stall_left = 0;
        hold_left = 0;
        sample_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && sample_ch.valid && sample_ch.ready) begin
                samples_checked++;
                if (sample_ch.is_last === 1'b1)
                    last_marks++;
                if (expected_samples.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Unexpected sample %0d (last %0b)",
                                 sample_ch.sample, sample_ch.is_last);
                    mismatch_count++;
                end
                else begin
                    exp_s = expected_samples.pop_front();
                    if (sample_ch.sample !== exp_s.sample || sample_ch.is_last !== exp_s.is_last) begin
                        if (mismatch_count < 10)
                            $display("Sample %0d: expected %0d last %0b, got %0d last %0b",
                                     samples_checked, exp_s.sample, exp_s.is_last,
                                     sample_ch.sample, sample_ch.is_last);
                        mismatch_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n) begin
                sample_ch.ready <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left--;
                sample_ch.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                sample_ch.ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                sample_ch.ready <= 1'b0;
            end
            else begin
                sample_ch.ready <= 1'b1;
            end
        end
    end

    // Lowers valid and waits until every expected sample is back, then lets the core settle.
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_PHASE_STEP)
            step_reg = data;
        else if (idx == REG_TONE_LENGTH)
            length_reg = data[INDEX_W-1:0];
        writes_done++;
    endtask

    task automatic configure(input bit write_step, input logic [31:0] step_data,
                             input bit write_len, input logic [31:0] len_data);
        wait_idle();
        if (write_step)
            write_reg(REG_PHASE_STEP, step_data);
        if (write_len)
            write_reg(REG_TONE_LENGTH, len_data);
        cfg_we <= 1'b0;
    endtask

    // Offers one request and predicts its sample once it is accepted.
    task automatic send_tick(input logic restart, input bit typed, input logic typed_last);
        tone_sample_t res;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        res = next_tone_sample(restart);
        if (typed)
            res.is_last = typed_last;
        expected_samples.push_back(res);
        requests_sent++;
    endtask

    initial begin : stimulus
        int random_sent;
        int phase_no;
        int burst;
        int mode;
        bit write_step;
        bit write_len;
        logic [31:0] step_data;
        logic [31:0] len_data;

        rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.restart = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        step_reg = '0;
        length_reg = TONE_LENGTH_RESET;
        tone_phase = '0;
        tone_index = '0;
        mismatch_count = 0;
        samples_checked = 0;
        last_marks = 0;
        requests_sent = 0;
        writes_done = 0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        hold_req = 1'b0;
        random_sent = 0;
        phase_no = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                if (r == 0 || directed_rows[r-1].kind != ROW_WRITE)
                    wait_idle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].data);
                if (r == DIRECTED_ROWS - 1 || directed_rows[r+1].kind != ROW_WRITE)
                    cfg_we <= 1'b0;
            end
            else begin
                send_tick(directed_rows[r].restart, 1'b1, directed_rows[r].exp_last);
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            sender_gaps = (random_sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            sink_stalls = (random_sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 9);
            step_data = $urandom;
            len_data = $urandom;
            write_step = 1'b1;
            write_len = 1'b1;
            if (mode < 5) begin
                len_data[INDEX_W-1:0] = 24'($urandom_range(1, 48));
            end
            else if (mode == 5) begin
                // Slow sweep over a long tone.
                step_data = $urandom_range(0, 255);
            end
            else if (mode == 6) begin
                step_data = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'h0;
                case ($urandom_range(0, 2))
                    0:       len_data[INDEX_W-1:0] = 24'h1;
                    1:       len_data[INDEX_W-1:0] = 24'hFFFFFF;
                    default: len_data[INDEX_W-1:0] = 24'h0;
                endcase
            end
            else if (mode == 7) begin
                // Length only, often below the running index.
                write_step = 1'b0;
                len_data[INDEX_W-1:0] = 24'($urandom_range(1, 8));
            end
            else if (mode == 8) begin
                write_len = 1'b0;
            end
            else begin
                len_data[INDEX_W-1:0] = 24'($urandom_range(1, 4));
            end
            configure(write_step, step_data, write_len, len_data);

            burst = $urandom_range(15, 60);
            for (int k = 0; k < burst; k++) begin
                if (phase_no == 4 && k == 5)
                    hold_req = 1'b1;
                if (phase_no == 7 && k == 10)
                    wait_idle();
                send_tick($urandom_range(0, 19) == 0, 1'b0, 1'b0);
                random_sent++;
            end
            phase_no++;
        end

        wait_idle();
        $display("Run covered %0d requests, %0d register writes over %0d random phases.",
                 requests_sent, writes_done, phase_no);
        $display("Checked %0d samples, %0d of them tone ends; %0d mismatches.",
                 samples_checked, last_marks, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
